[hdl/tsch_pkg.sv]
// shared constants, codes and types of the task scheduler table
`default_nettype none

package tsch_pkg;

	localparam int TASK_SLOTS = 16;
	localparam int TICK_MS    = 10;

	localparam int SLOT_W    = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int IDX_CNT_W = $clog2(TASK_SLOTS + 1);
	localparam int CODE_W    = 32;
	localparam int MS_W      = 24;
	localparam int TICKS_W   = 21;
	localparam int RUNS_W    = 8;
	localparam int MAX_OUT   = 16;
	localparam int CNT_W     = $clog2(MAX_OUT + 1);
	localparam int DIV_LANES = 2;

	localparam logic [TICKS_W-1:0] TIME_MAX = {TICKS_W{1'b1}};
	localparam logic [RUNS_W-1:0]  RUNS_MAX = {RUNS_W{1'b1}};

	localparam logic [1:0] CMD_ADD  = 2'd0;
	localparam logic [1:0] CMD_DEL  = 2'd1;
	localparam logic [1:0] CMD_TICK = 2'd2;
	localparam logic [1:0] CMD_DISP = 2'd3;

	localparam logic [1:0] STAT_DONE  = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;
	localparam logic [1:0] STAT_NONE  = 2'd3;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [TICKS_W-1:0] delay;
		logic [TICKS_W-1:0] period;
		logic [RUNS_W-1:0]  runs;
	} tsch_entry_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		tsch_entry_t       wdata;
		logic              re;
		logic [SLOT_W-1:0] raddr;
	} tsch_mem_req_t;

endpackage

`default_nettype wire

[hdl/cooperative_task_scheduler_table.sv]
// top level of the cooperative time-triggered task scheduler table
// commands come in on the in_* channel (valid/ready), one word per command:
//   add stores task_code, delay_ms/TICK_MS and period_ms/TICK_MS in the lowest
//   free slot; delete frees a slot; tick advances every used slot by one tick;
//   dispatch returns every slot with pending runs, one result word each.
// results leave on the out_* channel (valid/ready) from an output register;
// last marks the final result word of a command.
// one command is in work at a time; in_ready is high whenever the sequencer is
// idle, even while the previous result still sits in the output register.
// add does its divide as one reciprocal multiply into a register; tick walks
// the memory one slot per cycle; dispatch walks it the same way but pauses
// while the output stalls.
// slot state lives in a memory with a registered read port; reads run one slot
// ahead of the write-back, so read and write never hit the same entry.
// reset clears the slot-used flags and the control state, not the memory;
// contents of free slots are never looked at, so no clearing pass is needed.
// a stalled receiver holds the output register; dispatch then pauses its walk.
`default_nettype none

module cooperative_task_scheduler_table import tsch_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          cmd,
	input  logic [3:0]          slot,
	input  logic [CODE_W-1:0]   task_code,
	input  logic [MS_W-1:0]     delay_ms,
	input  logic [MS_W-1:0]     period_ms,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0]          slot_res,
	output logic [CODE_W-1:0]   task_code_res,
	output logic [1:0]          status,
	output logic                last
);

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [1:0]            state_q;
	logic [1:0]            cmd_q;
	logic [3:0]            slot_q;
	logic [CODE_W-1:0]     code_q;
	logic [SLOT_W-1:0]     free_idx_q;
	logic                  full_q;
	logic [1:0]            del_st_q;
	logic [TASK_SLOTS-1:0] used_q;

	// walk pipeline: read issue counter and the slot whose data is on the read port
	logic [IDX_CNT_W-1:0]  rd_idx_q;
	logic                  ev_v_s1;
	logic [SLOT_W-1:0]     ev_idx_s1;

	// dispatch: result count and one held result, so the final word can carry last
	logic [CNT_W-1:0]      cnt_q;
	logic                  hold_v_q;
	logic [SLOT_W-1:0]     hold_slot_q;
	logic [CODE_W-1:0]     hold_code_q;

	logic                  out_valid_q;
	logic [3:0]            slot_res_q;
	logic [CODE_W-1:0]     code_res_q;
	logic [1:0]            status_q;
	logic                  last_q;

	tsch_mem_req_t                     mem_req;
	tsch_entry_t                       ev;
	logic                              div_start;
	logic                              div_done;
	logic [DIV_LANES-1:0][MS_W-1:0]    div_ms;
	logic [DIV_LANES-1:0][TICKS_W-1:0] div_ticks;

	logic                  accept;
	logic                  out_free;
	logic [SLOT_W-1:0]     free_idx;
	logic                  table_full;
	logic                  del_in_range;
	logic [SLOT_W-1:0]     del_idx;
	logic                  ev_used;
	logic                  disp_emit;
	logic                  ev_ok;
	logic                  adv;
	logic                  more;
	logic                  push;
	logic [3:0]            push_slot;
	logic [CODE_W-1:0]     push_code;
	logic [1:0]            push_status;
	logic                  push_last;
	tsch_entry_t           tick_entry;
	tsch_entry_t           disp_entry;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i])
				free_idx = SLOT_W'(i);
		end
	end
	assign table_full   = &used_q;
	assign del_in_range = (32'(slot) < 32'(TASK_SLOTS));
	assign del_idx      = SLOT_W'(slot);

	// per-slot update on the data coming back from memory
	assign ev_used = used_q[ev_idx_s1];
	assign more    = (rd_idx_q < IDX_CNT_W'(TASK_SLOTS));

	always_comb begin
		tick_entry = ev;
		if (ev.delay == '0) begin
			if (ev.runs != RUNS_MAX)
				tick_entry.runs = ev.runs + RUNS_W'(1);
			if (ev.period != '0)
				tick_entry.delay = ev.period;
		end else begin
			tick_entry.delay = ev.delay - TICKS_W'(1);
		end
	end

	always_comb begin
		disp_entry      = ev;
		disp_entry.runs = ev.runs - RUNS_W'(1);
	end

	assign disp_emit = (state_q == S_WALK) && (cmd_q == CMD_DISP) && ev_v_s1 && ev_used
		&& (ev.runs != '0) && (cnt_q < CNT_W'(MAX_OUT));
	// a new dispatch hit pushes the held one out, which needs room at the output
	assign ev_ok = !disp_emit || !hold_v_q || out_free;
	assign adv   = !ev_v_s1 || ev_ok;

	// memory requests
	always_comb begin
		mem_req       = '0;
		mem_req.raddr = rd_idx_q[SLOT_W-1:0];
		mem_req.re    = (state_q == S_WALK) && adv && more;
		mem_req.waddr = ev_idx_s1;
		mem_req.wdata = (cmd_q == CMD_TICK) ? tick_entry : disp_entry;
		if (state_q == S_WALK) begin
			mem_req.we = ev_v_s1 && ev_ok
				&& (((cmd_q == CMD_TICK) && ev_used) || disp_emit);
		end else if (state_q == S_DIV) begin
			mem_req.we           = div_done;
			mem_req.waddr        = free_idx_q;
			mem_req.wdata.code   = code_q;
			mem_req.wdata.delay  = div_ticks[0];
			mem_req.wdata.period = div_ticks[1];
			mem_req.wdata.runs   = '0;
		end
	end

	tsch_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (ev)
	);

	assign div_start = accept && (cmd == CMD_ADD) && !table_full;
	assign div_ms[0] = delay_ms;
	assign div_ms[1] = period_ms;

	tsch_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.ms     (div_ms),
		.done   (div_done),
		.ticks  (div_ticks)
	);

	// result word into the output register
	always_comb begin
		push        = 1'b0;
		push_slot   = '0;
		push_code   = '0;
		push_status = STAT_DONE;
		push_last   = 1'b1;
		if (state_q == S_WALK) begin
			// held dispatch word goes out, not the last one
			push      = disp_emit && hold_v_q && out_free;
			push_slot = 4'(hold_slot_q);
			push_code = hold_code_q;
			push_last = 1'b0;
		end else if (state_q == S_FIN) begin
			push = out_free;
			case (cmd_q)
				CMD_ADD: begin
					push_slot   = full_q ? 4'd0 : 4'(free_idx_q);
					push_status = full_q ? STAT_FULL : STAT_DONE;
				end
				CMD_DEL: begin
					push_slot   = slot_q;
					push_status = del_st_q;
				end
				CMD_TICK: begin
					push_status = STAT_DONE;
				end
				CMD_DISP: begin
					if (hold_v_q) begin
						push_slot = 4'(hold_slot_q);
						push_code = hold_code_q;
					end else begin
						push_status = STAT_NONE;
					end
				end
				default: begin
					push_status = STAT_DONE;
				end
			endcase
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			ev_v_s1     <= 1'b0;
			hold_v_q    <= 1'b0;
			cnt_q       <= '0;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (cmd)
							CMD_ADD: begin
								state_q <= table_full ? S_FIN : S_DIV;
							end
							CMD_DEL: begin
								if (del_in_range)
									used_q[del_idx] <= 1'b0;
								state_q <= S_FIN;
							end
							default: begin
								// tick and dispatch walk every slot
								state_q  <= S_WALK;
								rd_idx_q <= '0;
								ev_v_s1  <= 1'b0;
								cnt_q    <= '0;
								hold_v_q <= 1'b0;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						used_q[free_idx_q] <= 1'b1;
						state_q            <= S_FIN;
					end
				end
				S_WALK: begin
					if (disp_emit && ev_ok) begin
						hold_v_q <= 1'b1;
						cnt_q    <= cnt_q + CNT_W'(1);
						// one-shot task leaves the table once it has run
						if (ev.period == '0)
							used_q[ev_idx_s1] <= 1'b0;
					end
					if (adv) begin
						if (more) begin
							rd_idx_q <= rd_idx_q + IDX_CNT_W'(1);
							ev_v_s1  <= 1'b1;
						end else begin
							ev_v_s1 <= 1'b0;
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd;
			slot_q     <= slot;
			code_q     <= task_code;
			free_idx_q <= free_idx;
			full_q     <= table_full;
			del_st_q   <= (del_in_range && used_q[del_idx]) ? STAT_DONE : STAT_EMPTY;
		end
		if ((state_q == S_WALK) && adv && more)
			ev_idx_s1 <= rd_idx_q[SLOT_W-1:0];
		if (disp_emit && ev_ok) begin
			hold_slot_q <= ev_idx_s1;
			hold_code_q <= ev.code;
		end
		if (push) begin
			slot_res_q <= push_slot;
			code_res_q <= push_code;
			status_q   <= push_status;
			last_q     <= push_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign slot_res      = slot_res_q;
	assign task_code_res = code_res_q;
	assign status        = status_q;
	assign last          = last_q;

	// read-ahead never touches the entry being written back
	a_no_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
		else $error("memory read and write hit the same slot");

	// an add only ever fills a slot that was free
	a_add_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DIV) && div_done) |-> !used_q[free_idx_q])
		else $error("add overwrote a used slot");

	// divider finishes only while the sequencer waits for it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider done outside of add");

	// dispatch result count stays within its bound
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_OUT))
		else $error("dispatch emitted too many words");

	// nothing left in flight on the read port once idle
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !ev_v_s1)
		else $error("walk data pending while idle");

endmodule

`default_nettype wire

[hdl/tsch_div.sv]
// two-lane divider by the tick length, reciprocal multiply into a result register
`default_nettype none

module tsch_div import tsch_pkg::*; (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [DIV_LANES-1:0][MS_W-1:0]     ms,
	output logic                               done,
	output logic [DIV_LANES-1:0][TICKS_W-1:0]  ticks
);

	// quotient = (ms * RECIP) >> SHIFT, exact for every MS_W-bit input
	localparam int SHIFT   = MS_W + $clog2(TICK_MS);
	localparam int RECIP_W = MS_W + 1;
	localparam int PROD_W  = MS_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((longint'(1) << SHIFT) + longint'(TICK_MS) - 1) / longint'(TICK_MS));

	logic [DIV_LANES-1:0][TICKS_W-1:0] ticks_d;
	logic [DIV_LANES-1:0][TICKS_W-1:0] ticks_q;
	logic                              done_q;

	always_comb begin
		logic [PROD_W-1:0] prod;
		logic [MS_W-1:0]   quo;
		prod = '0;
		quo  = '0;
		for (int l = 0; l < DIV_LANES; l++) begin
			prod = PROD_W'(ms[l]) * PROD_W'(RECIP);
			quo  = MS_W'(prod >> SHIFT);
			if (quo > MS_W'(TIME_MAX))
				ticks_d[l] = TIME_MAX;
			else
				ticks_d[l] = quo[TICKS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= start;
	end

	always_ff @(posedge clk) begin
		if (start)
			ticks_q <= ticks_d;
	end

	assign done  = done_q;
	assign ticks = ticks_q;

endmodule

`default_nettype wire

[hdl/tsch_mem.sv]
// slot memory: one write port, one registered read port
`default_nettype none

module tsch_mem import tsch_pkg::*; (
	input  logic          clk,
	input  tsch_mem_req_t req,
	output tsch_entry_t   rdata
);

	tsch_entry_t mem_q [TASK_SLOTS];
	tsch_entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we)
			mem_q[req.waddr] <= req.wdata;
		if (req.re)
			rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[tb/sv/tb_cooperative_task_scheduler_table.sv]
// self-checking testbench for the cooperative task scheduler table
module tb_cooperative_task_scheduler_table;
	timeunit 1ns;
	timeprecision 1ps;

	import tsch_pkg::*;

	// one command word as queued for the driver, with its own pacing
	typedef struct packed {
		logic [1:0]        op;
		logic [3:0]        idx;
		logic [CODE_W-1:0] code;
		logic [MS_W-1:0]   dly;
		logic [MS_W-1:0]   per;
		logic [3:0]        lead;     // idle cycles before the word is offered
		logic              sync;     // wait until every result word is back
		logic              squeeze;  // start the long output hold here
	} cmd_word_t;

	// one result word as the scheduler should return it
	typedef struct packed {
		logic [3:0]        res_slot;
		logic [CODE_W-1:0] res_code;
		logic [1:0]        res_status;
		logic              res_last;
	} result_word_t;

	localparam int HOLD_CYCLES = 300;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [1:0]        cmd = CMD_TICK;
	logic [3:0]        slot = '0;
	logic [CODE_W-1:0] task_code = '0;
	logic [MS_W-1:0]   delay_ms = '0;
	logic [MS_W-1:0]   period_ms = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [3:0]        slot_res;
	logic [CODE_W-1:0] task_code_res;
	logic [1:0]        status;
	logic              last;

	cooperative_task_scheduler_table uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.slot          (slot),
		.task_code     (task_code),
		.delay_ms      (delay_ms),
		.period_ms     (period_ms),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.slot_res      (slot_res),
		.task_code_res (task_code_res),
		.status        (status),
		.last          (last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// shadow copy of the slot table, updated as each command word is taken
	// ------------------------------------------------------------------
	logic              sched_used   [TASK_SLOTS];
	logic [CODE_W-1:0] sched_code   [TASK_SLOTS];
	logic [TICKS_W-1:0] sched_delay [TASK_SLOTS];
	logic [TICKS_W-1:0] sched_period[TASK_SLOTS];
	logic [RUNS_W-1:0] sched_runs   [TASK_SLOTS];

	result_word_t due_words[$];    // result words still owed by the scheduler
	cmd_word_t    pending_cmds[$]; // command words not yet offered
	int           outstanding = 0; // due_words size as seen by other processes

	int err_cnt = 0;
	int words_checked = 0;
	int op_tally[4] = '{0, 0, 0, 0};
	int full_hits = 0;
	int none_hits = 0;
	int sat_hits = 0;

	// stimulus-building knobs
	bit calm = 1'b0;
	bit barrier_next = 1'b0;
	bit squeeze_next = 1'b0;

	// ms to ticks, clipped to the width of the delay counters
	function automatic logic [TICKS_W-1:0] ms_to_ticks(input logic [MS_W-1:0] ms);
		logic [MS_W-1:0] q;
		q = MS_W'(ms / TICK_MS);
		return (q > TIME_MAX) ? TIME_MAX : q[TICKS_W-1:0];
	endfunction

	function automatic void clear_slot(input int i);
		sched_used[i]   = 1'b0;
		sched_code[i]   = '0;
		sched_delay[i]  = '0;
		sched_period[i] = '0;
		sched_runs[i]   = '0;
	endfunction

	function automatic void push_word(input logic [3:0] s, input logic [CODE_W-1:0] c,
		input logic [1:0] st);
		result_word_t w;
		w.res_slot   = s;
		w.res_code   = c;
		w.res_status = st;
		w.res_last   = 1'b0;
		due_words.push_back(w);
	endfunction

	// work out the result words of one command and move the table on
	task automatic predict_command(input logic [1:0] op, input logic [3:0] idx,
		input logic [CODE_W-1:0] code, input logic [MS_W-1:0] dly,
		input logic [MS_W-1:0] per);
		int pos;
		int made;
		result_word_t w;
		made = 0;
		op_tally[op]++;
		case (op)
			CMD_ADD: begin
				// lowest free slot wins
				pos = 0;
				while (pos < TASK_SLOTS && sched_used[pos])
					pos++;
				if (pos >= TASK_SLOTS) begin
					push_word(4'd0, '0, STAT_FULL);
					full_hits++;
				end else begin
					sched_used[pos]   = 1'b1;
					sched_code[pos]   = code;
					sched_delay[pos]  = ms_to_ticks(dly);
					sched_period[pos] = ms_to_ticks(per);
					sched_runs[pos]   = '0;
					push_word(pos[3:0], '0, STAT_DONE);
				end
			end
			CMD_DEL: begin
				if (idx < TASK_SLOTS) begin
					push_word(idx, '0, sched_used[idx] ? STAT_DONE : STAT_EMPTY);
					clear_slot(int'(idx));
				end else begin
					push_word(idx, '0, STAT_EMPTY);
				end
			end
			CMD_TICK: begin
				for (int i = 0; i < TASK_SLOTS; i++) begin
					if (sched_used[i]) begin
						if (sched_delay[i] == '0) begin
							// due: one more run owed, count sticks at the top
							if (sched_runs[i] != RUNS_MAX) begin
								sched_runs[i]++;
								if (sched_runs[i] == RUNS_MAX)
									sat_hits++;
							end
							if (sched_period[i] != '0)
								sched_delay[i] = sched_period[i];
						end else begin
							sched_delay[i]--;
						end
					end
				end
				push_word(4'd0, '0, STAT_DONE);
			end
			default: begin
				// dispatch: every slot with runs owed, ascending, one run each
				for (int i = 0; i < TASK_SLOTS && made < MAX_OUT; i++) begin
					if (sched_used[i] && sched_runs[i] != '0) begin
						push_word(i[3:0], sched_code[i], STAT_DONE);
						made++;
						sched_runs[i]--;
						// one-shot task leaves once it has run
						if (sched_period[i] == '0)
							clear_slot(i);
					end
				end
				if (made == 0) begin
					push_word(4'd0, '0, STAT_NONE);
					none_hits++;
				end
			end
		endcase
		// flag the final word of this command
		w = due_words.pop_back();
		w.res_last = 1'b1;
		due_words.push_back(w);
	endtask

	// ------------------------------------------------------------------
	// monitor: predicts on every accepted command word, checks every result
	// word in order; both sides sampled at the same edge, before any update
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		result_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++)
				clear_slot(i);
			due_words.delete();
			outstanding <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_command(cmd, slot, task_code, delay_ms, period_ms);
			if (out_valid && out_ready) begin
				if (due_words.size() == 0) begin
					$error("result word with nothing owed: slot_res %0d status %0d",
						slot_res, status);
					err_cnt++;
				end else begin
					want = due_words.pop_front();
					words_checked++;
					if (slot_res !== want.res_slot) begin
						$error("slot_res mismatch: expected %0d, got %0d",
							want.res_slot, slot_res);
						err_cnt++;
					end
					if (task_code_res !== want.res_code) begin
						$error("task_code_res mismatch: expected %h, got %h",
							want.res_code, task_code_res);
						err_cnt++;
					end
					if (status !== want.res_status) begin
						$error("status mismatch: expected %0d, got %0d",
							want.res_status, status);
						err_cnt++;
					end
					if (last !== want.res_last) begin
						$error("last mismatch: expected %0d, got %0d",
							want.res_last, last);
						err_cnt++;
					end
				end
			end
			outstanding <= due_words.size();
		end
	end

	// ------------------------------------------------------------------
	// driver: offers queued command words, holding each until taken
	// ------------------------------------------------------------------
	logic [3:0] lead_cnt = '0;
	logic       squeeze_go = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		cmd_word_t w;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			cmd       <= CMD_TICK;
			slot      <= '0;
			task_code <= '0;
			delay_ms  <= '0;
			period_ms <= '0;
			lead_cnt  <= '0;
		end else if (!in_valid || in_ready) begin
			// nothing on the port, or the current word goes in at this edge
			if (pending_cmds.size() == 0) begin
				in_valid <= 1'b0;
			end else begin
				w = pending_cmds[0];
				if (w.sync && (in_valid || outstanding != 0)) begin
					// barrier: let the scheduler drain every owed word first
					in_valid <= 1'b0;
				end else if (lead_cnt < w.lead) begin
					lead_cnt <= lead_cnt + 4'd1;
					in_valid <= 1'b0;
				end else begin
					void'(pending_cmds.pop_front());
					in_valid  <= 1'b1;
					cmd       <= w.op;
					slot      <= w.idx;
					task_code <= w.code;
					delay_ms  <= w.dly;
					period_ms <= w.per;
					lead_cnt  <= '0;
					if (w.squeeze)
						squeeze_go <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// receiver: random stall after each result word, quiet stretches with
	// no stall, and one long hold while the driver keeps pushing
	// ------------------------------------------------------------------
	int  stall_left = 0;
	int  taken = 0;
	bit  squeezed = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		int nxt;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
			taken      <= 0;
		end else begin
			nxt = stall_left;
			if (squeeze_go && !squeezed) begin
				nxt = HOLD_CYCLES;
				squeezed <= 1'b1;
			end else if (out_valid && out_ready) begin
				taken <= taken + 1;
				if (((taken + 1) / 48) % 3 == 0)
					nxt = 0;
				else
					nxt = $urandom_range(0, 14);
			end else if (nxt > 0) begin
				nxt = nxt - 1;
			end
			stall_left <= nxt;
			out_ready  <= (nxt == 0);
		end
	end

	// queue one command word; the pacing knobs are consumed here
	task automatic queue_cmd(input logic [1:0] op, input logic [3:0] idx,
		input logic [CODE_W-1:0] code, input logic [MS_W-1:0] dly,
		input logic [MS_W-1:0] per);
		cmd_word_t w;
		w.op      = op;
		w.idx     = idx;
		w.code    = code;
		w.dly     = dly;
		w.per     = per;
		w.lead    = calm ? 4'd0 : 4'($urandom_range(0, 14));
		w.sync    = barrier_next;
		w.squeeze = squeeze_next;
		barrier_next = 1'b0;
		squeeze_next = 1'b0;
		pending_cmds.push_back(w);
	endtask

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int r;
		logic [MS_W-1:0] d;
		logic [MS_W-1:0] p;

		// directed: empty table first
		queue_cmd(CMD_DISP, 4'hF, $urandom, 24'($urandom), 24'($urandom)); // nothing ready
		queue_cmd(CMD_DEL, 4'd15, $urandom, 24'($urandom), 24'($urandom)); // empty slot
		// one-shot due at once, all-zero fields
		queue_cmd(CMD_ADD, 4'd0, '0, '0, '0);
		// all-ones fields, largest delay and period
		queue_cmd(CMD_ADD, 4'hF, '1, '1, '1);
		// fill the rest: one-shot just below a tick, one-tick period, longer periods
		for (int k = 2; k < TASK_SLOTS; k++) begin
			if (k % 3 == 0)
				p = 24'd9;
			else if (k % 3 == 1)
				p = 24'd10;
			else
				p = 24'($urandom_range(11, 40));
			queue_cmd(CMD_ADD, 4'($urandom), $urandom, 24'($urandom_range(0, 30)), p);
		end
		queue_cmd(CMD_ADD, 4'($urandom), $urandom, 24'($urandom), 24'($urandom)); // full
		queue_cmd(CMD_TICK, 4'($urandom), $urandom, 24'($urandom), 24'($urandom));
		queue_cmd(CMD_DISP, 4'($urandom), $urandom, 24'($urandom), 24'($urandom));
		queue_cmd(CMD_DEL, 4'd1, $urandom, 24'($urandom), 24'($urandom));     // used slot
		queue_cmd(CMD_DEL, 4'd0, $urandom, 24'($urandom), 24'($urandom));     // one-shot gone
		queue_cmd(CMD_TICK, 4'($urandom), $urandom, 24'($urandom), 24'($urandom));
		queue_cmd(CMD_TICK, 4'($urandom), $urandom, 24'($urandom), 24'($urandom));
		queue_cmd(CMD_DISP, 4'($urandom), $urandom, 24'($urandom), 24'($urandom));
		// clear the table for the random part
		for (int k = 0; k < TASK_SLOTS; k++)
			queue_cmd(CMD_DEL, k[3:0], $urandom, 24'($urandom), 24'($urandom));

		// random: mostly short-delay tasks that actually come due
		barrier_next = 1'b1;
		for (int k = 0; k < 128; k++) begin
			calm = (k >= 60 && k < 90);
			if (k == 100)
				squeeze_next = 1'b1;
			if (k == 115)
				barrier_next = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 28) begin
				d = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 60));
				r = $urandom_range(0, 99);
				if (r < 30)
					p = 24'($urandom_range(0, 9));
				else if (r < 90)
					p = 24'($urandom_range(10, 60));
				else
					p = 24'($urandom);
				queue_cmd(CMD_ADD, 4'($urandom), $urandom, d, p);
			end else if (r < 40) begin
				queue_cmd(CMD_DEL, 4'($urandom), $urandom, 24'($urandom), 24'($urandom));
			end else if (r < 72) begin
				queue_cmd(CMD_TICK, 4'($urandom), $urandom, 24'($urandom), 24'($urandom));
			end else begin
				queue_cmd(CMD_DISP, 4'($urandom), $urandom, 24'($urandom), 24'($urandom));
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// everything offered, taken and answered
		do
			@(posedge clk);
		while (pending_cmds.size() != 0 || in_valid || outstanding != 0);
		// short tail to catch stray result words
		repeat (60) @(posedge clk);

		$display("run covered %0d adds, %0d deletes, %0d ticks, %0d dispatches, %0d words checked",
			op_tally[CMD_ADD], op_tally[CMD_DEL], op_tally[CMD_TICK], op_tally[CMD_DISP],
			words_checked);
		$display("table full %0d times, nothing ready %0d times, run count pinned %0d times",
			full_hits, none_hits, sat_hits);
		if (err_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// hard stop, several times the slowest legal run
	initial begin
		#5_000_000;
		$display("timeout with %0d result words still owed", outstanding);
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
